FILE: design/edc_pkg.sv
`default_nettype none

package edc_pkg;

  // Width of a disk mass.
  localparam int MASS_W = 16;

  // Number of velocity components corrected in parallel.
  localparam int LANES = 4;

  // Lane order of the four velocity components.
  localparam int LANE_FIRST_VX  = 0;
  localparam int LANE_FIRST_VY  = 1;
  localparam int LANE_SECOND_VX = 2;
  localparam int LANE_SECOND_VY = 3;

  // Control that travels with each dividend through the divider.
  typedef struct packed {
    logic vld;
    logic hit;
    logic neg;
  } edc_ctl_t;

endpackage

`default_nettype wire

FILE: design/edc_div.sv
`default_nettype none

module edc_div #(
  parameter int PW   = 117,
  parameter int DENW = 83,
  parameter int QB   = 36,
  parameter int VW   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire edc_pkg::edc_ctl_t    in_ctl,
  input  wire logic [PW-1:0]        in_num,
  input  wire logic [DENW-1:0]      in_den,
  input  wire logic [VW-1:0]        in_val,
  output edc_pkg::edc_ctl_t         out_ctl,
  output logic [QB-1:0]             out_q,
  output logic                      out_rnd,
  output logic [VW-1:0]             out_val
);
  import edc_pkg::*;

  // One quotient bit per stage; stage 0 only loads the operands.
  edc_ctl_t          ctl_r [QB+1];
  logic [DENW-1:0]   rem_r [QB+1];
  logic [DENW-1:0]   den_r [QB+1];
  logic [QB-1:0]     low_r [QB+1];
  logic [QB-1:0]     q_r   [QB+1];
  logic [VW-1:0]     val_r [QB+1];
  edc_ctl_t          out_ctl_r;
  logic [QB-1:0]     out_q_r;
  logic              out_rnd_r;
  logic [VW-1:0]     out_val_r;
  logic              rnd_nxt;

  // Load the high part of the dividend as the first partial remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
    end
    rem_r[0] <= DENW'(in_num[PW-1:QB]);
    low_r[0] <= in_num[QB-1:0];
    den_r[0] <= in_den;
    q_r[0]   <= '0;
    val_r[0] <= in_val;
  end

  // Restoring division stages, most significant quotient bit first.
  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [DENW:0] trial;
    logic [DENW:0] sub_res;
    logic          ge;

    always_comb begin
      trial   = {rem_r[s], low_r[s][QB-1]};
      sub_res = trial - {1'b0, den_r[s]};
      ge      = (trial >= {1'b0, den_r[s]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1] <= '0;
      end else begin
        ctl_r[s+1] <= ctl_r[s];
      end
      rem_r[s+1] <= ge ? sub_res[DENW-1:0] : trial[DENW-1:0];
      low_r[s+1] <= {low_r[s][QB-2:0], 1'b0};
      den_r[s+1] <= den_r[s];
      q_r[s+1]   <= {q_r[s][QB-2:0], ge};
      val_r[s+1] <= val_r[s];
    end
  end

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign rnd_nxt = ({rem_r[QB], 1'b0} >= {1'b0, den_r[QB]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else begin
      out_ctl_r <= ctl_r[QB];
    end
    out_q_r   <= q_r[QB];
    out_rnd_r <= rnd_nxt;
    out_val_r <= val_r[QB];
  end

  assign out_ctl = out_ctl_r;
  assign out_q   = out_q_r;
  assign out_rnd = out_rnd_r;
  assign out_val = out_val_r;

endmodule

`default_nettype wire

FILE: design/elastic_disk_collision_top.sv
// Pipeline from the accepting edge to the result strobe: nine arithmetic stages, a divider of
// VALUE_WIDTH + 6 stages that yields one quotient bit per stage, then three stages of rounding
// and saturation.
// Throughput: one transaction per cycle; busy stays low and the receiver cannot stall.
// Reset (synchronous, rst_n low) clears every valid bit; data registers are not reset.
`default_nettype none

module elastic_disk_collision_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] in_first_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_first_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_first_vx,
  input  wire logic signed [VALUE_WIDTH-1:0] in_first_vy,
  input  wire logic [edc_pkg::MASS_W-1:0]    in_first_mass,
  input  wire logic [VALUE_WIDTH-2:0]        in_first_radius,
  input  wire logic signed [VALUE_WIDTH-1:0] in_second_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_second_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_second_vx,
  input  wire logic signed [VALUE_WIDTH-1:0] in_second_vy,
  input  wire logic [edc_pkg::MASS_W-1:0]    in_second_mass,
  input  wire logic [VALUE_WIDTH-2:0]        in_second_radius,
  output logic                               out_valid,
  output logic signed [VALUE_WIDTH-1:0]      out_new_first_vx,
  output logic signed [VALUE_WIDTH-1:0]      out_new_first_vy,
  output logic signed [VALUE_WIDTH-1:0]      out_new_second_vx,
  output logic signed [VALUE_WIDTH-1:0]      out_new_second_vy,
  output logic                               out_collided
);
  import edc_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int MW   = MASS_W + 1;
  localparam int DW   = 2 * W + 2;
  localparam int DMW  = 2 * W + 3;
  localparam int KL   = W + 2;
  localparam int KH   = DMW - KL;
  localparam int KW   = DMW + MW;
  localparam int C    = (KW + 2) / 3;
  localparam int C2   = KW - 2 * C;
  localparam int PW   = (W + 1) + KW;
  localparam int DENW = DW + MW;
  localparam int QB   = W + 4;
  localparam int SW   = W + 7;

  // The pipeline never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: center offsets, radius sum and total mass.
  logic                    s1_vld_r;
  logic signed [W:0]       s1_nx_r, s1_ny_r;
  logic [W-1:0]            s1_rsum_r;
  logic [MASS_W-1:0]       s1_m1_r, s1_m2_r;
  logic [MW-1:0]           s1_mt_r;
  logic signed [W-1:0]     s1_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    s1_nx_r   <= (W+1)'(in_second_x) - (W+1)'(in_first_x);
    s1_ny_r   <= (W+1)'(in_second_y) - (W+1)'(in_first_y);
    s1_rsum_r <= {1'b0, in_first_radius} + {1'b0, in_second_radius};
    s1_m1_r   <= in_first_mass;
    s1_m2_r   <= in_second_mass;
    s1_mt_r   <= {1'b0, in_first_mass} + {1'b0, in_second_mass};
    s1_v_r[LANE_FIRST_VX]  <= in_first_vx;
    s1_v_r[LANE_FIRST_VY]  <= in_first_vy;
    s1_v_r[LANE_SECOND_VX] <= in_second_vx;
    s1_v_r[LANE_SECOND_VY] <= in_second_vy;
  end

  // Stage 2: squares and the four projection products.
  logic                    s2_vld_r;
  logic [DW-1:0]           s2_nx2_r, s2_ny2_r;
  logic [2*W-1:0]          s2_rsq_r;
  logic signed [2*W:0]     s2_pr_r [LANES];
  logic signed [W:0]       s2_nx_r, s2_ny_r;
  logic [MASS_W-1:0]       s2_m1_r, s2_m2_r;
  logic [MW-1:0]           s2_mt_r;
  logic signed [W-1:0]     s2_v_r [LANES];
  logic signed [DW-1:0]    sq_x, sq_y;

  assign sq_x = s1_nx_r * s1_nx_r;
  assign sq_y = s1_ny_r * s1_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_nx2_r <= sq_x;
    s2_ny2_r <= sq_y;
    s2_rsq_r <= s1_rsum_r * s1_rsum_r;
    s2_pr_r[LANE_FIRST_VX]  <= s1_nx_r * s1_v_r[LANE_FIRST_VX];
    s2_pr_r[LANE_FIRST_VY]  <= s1_ny_r * s1_v_r[LANE_FIRST_VY];
    s2_pr_r[LANE_SECOND_VX] <= s1_nx_r * s1_v_r[LANE_SECOND_VX];
    s2_pr_r[LANE_SECOND_VY] <= s1_ny_r * s1_v_r[LANE_SECOND_VY];
    s2_nx_r  <= s1_nx_r;
    s2_ny_r  <= s1_ny_r;
    s2_m1_r  <= s1_m1_r;
    s2_m2_r  <= s1_m2_r;
    s2_mt_r  <= s1_mt_r;
    s2_v_r   <= s1_v_r;
  end

  // Stage 3: squared distance and the two dot products.
  logic                    s3_vld_r;
  logic [DW-1:0]           s3_dist2_r;
  logic [2*W-1:0]          s3_rsq_r;
  logic signed [DW-1:0]    s3_dot1_r, s3_dot2_r;
  logic signed [W:0]       s3_nx_r, s3_ny_r;
  logic [MASS_W-1:0]       s3_m1_r, s3_m2_r;
  logic [MW-1:0]           s3_mt_r;
  logic signed [W-1:0]     s3_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_dist2_r <= s2_nx2_r + s2_ny2_r;
    s3_rsq_r   <= s2_rsq_r;
    s3_dot1_r  <= DW'(s2_pr_r[LANE_FIRST_VX]) + DW'(s2_pr_r[LANE_FIRST_VY]);
    s3_dot2_r  <= DW'(s2_pr_r[LANE_SECOND_VX]) + DW'(s2_pr_r[LANE_SECOND_VY]);
    s3_nx_r    <= s2_nx_r;
    s3_ny_r    <= s2_ny_r;
    s3_m1_r    <= s2_m1_r;
    s3_m2_r    <= s2_m2_r;
    s3_mt_r    <= s2_mt_r;
    s3_v_r     <= s2_v_r;
  end

  // Stage 4: collision test and the difference of the projections.
  logic                    s4_vld_r, s4_hit_r;
  logic [DW-1:0]           s4_dist2_r;
  logic signed [DMW-1:0]   s4_diff_r;
  logic signed [W:0]       s4_nx_r, s4_ny_r;
  logic [MASS_W-1:0]       s4_m1_r, s4_m2_r;
  logic [MW-1:0]           s4_mt_r;
  logic signed [W-1:0]     s4_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_hit_r   <= (s3_dist2_r != '0) && (s3_dist2_r <= {2'b00, s3_rsq_r}) &&
                  (s3_mt_r != '0);
    s4_diff_r  <= DMW'(s3_dot2_r) - DMW'(s3_dot1_r);
    s4_dist2_r <= s3_dist2_r;
    s4_nx_r    <= s3_nx_r;
    s4_ny_r    <= s3_ny_r;
    s4_m1_r    <= s3_m1_r;
    s4_m2_r    <= s3_m2_r;
    s4_mt_r    <= s3_mt_r;
    s4_v_r     <= s3_v_r;
  end

  // Stage 5: magnitudes and signs, partial products of the divisor.
  logic                    s5_vld_r, s5_hit_r;
  logic [DMW-1:0]          s5_dmag_r;
  logic                    s5_dneg_r;
  logic [W:0]              s5_nxm_r, s5_nym_r;
  logic                    s5_nxneg_r, s5_nyneg_r;
  logic [W+MW:0]           s5_den_lo_r, s5_den_hi_r;
  logic [MW-1:0]           s5_m1x2_r, s5_m2x2_r;
  logic signed [W-1:0]     s5_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_hit_r    <= s4_hit_r;
    s5_dneg_r   <= s4_diff_r[DMW-1];
    s5_dmag_r   <= s4_diff_r[DMW-1] ? DMW'(-s4_diff_r) : DMW'(s4_diff_r);
    s5_nxneg_r  <= s4_nx_r[W];
    s5_nyneg_r  <= s4_ny_r[W];
    s5_nxm_r    <= s4_nx_r[W] ? (W+1)'(-s4_nx_r) : (W+1)'(s4_nx_r);
    s5_nym_r    <= s4_ny_r[W] ? (W+1)'(-s4_ny_r) : (W+1)'(s4_ny_r);
    s5_den_lo_r <= s4_mt_r * s4_dist2_r[W:0];
    s5_den_hi_r <= s4_mt_r * s4_dist2_r[DW-1:W+1];
    s5_m1x2_r   <= {s4_m1_r, 1'b0};
    s5_m2x2_r   <= {s4_m2_r, 1'b0};
    s5_v_r      <= s4_v_r;
  end

  // Stage 6: divisor sum and partial products of the mass factors.
  logic                    s6_vld_r, s6_hit_r, s6_dneg_r;
  logic [DENW-1:0]         s6_den_r;
  logic [KL+MW-1:0]        s6_ka_lo_r, s6_kb_lo_r;
  logic [KH+MW-1:0]        s6_ka_hi_r, s6_kb_hi_r;
  logic [W:0]              s6_nxm_r, s6_nym_r;
  logic                    s6_nxneg_r, s6_nyneg_r;
  logic signed [W-1:0]     s6_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    s6_hit_r   <= s5_hit_r;
    s6_dneg_r  <= s5_dneg_r;
    s6_den_r   <= DENW'(s5_den_lo_r) + (DENW'(s5_den_hi_r) << (W + 1));
    s6_ka_lo_r <= s5_m2x2_r * s5_dmag_r[KL-1:0];
    s6_ka_hi_r <= s5_m2x2_r * s5_dmag_r[DMW-1:KL];
    s6_kb_lo_r <= s5_m1x2_r * s5_dmag_r[KL-1:0];
    s6_kb_hi_r <= s5_m1x2_r * s5_dmag_r[DMW-1:KL];
    s6_nxm_r   <= s5_nxm_r;
    s6_nym_r   <= s5_nym_r;
    s6_nxneg_r <= s5_nxneg_r;
    s6_nyneg_r <= s5_nyneg_r;
    s6_v_r     <= s5_v_r;
  end

  // Stage 7: mass factors; the second disk's factor has the opposite sign.
  logic                    s7_vld_r, s7_hit_r, s7_dneg_r;
  logic [DENW-1:0]         s7_den_r;
  logic [KW-1:0]           s7_ka_r, s7_kb_r;
  logic [W:0]              s7_nxm_r, s7_nym_r;
  logic                    s7_nxneg_r, s7_nyneg_r;
  logic signed [W-1:0]     s7_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
    s7_hit_r   <= s6_hit_r;
    s7_dneg_r  <= s6_dneg_r;
    s7_den_r   <= s6_den_r;
    s7_ka_r    <= KW'(s6_ka_lo_r) + (KW'(s6_ka_hi_r) << KL);
    s7_kb_r    <= KW'(s6_kb_lo_r) + (KW'(s6_kb_hi_r) << KL);
    s7_nxm_r   <= s6_nxm_r;
    s7_nym_r   <= s6_nym_r;
    s7_nxneg_r <= s6_nxneg_r;
    s7_nyneg_r <= s6_nyneg_r;
    s7_v_r     <= s6_v_r;
  end

  // Stage 8: dividend partial products, three chunks of the mass factor per lane.
  logic                    s8_vld_r, s8_hit_r;
  logic [DENW-1:0]         s8_den_r;
  logic [W+C:0]            s8_pp0_r [LANES];
  logic [W+C:0]            s8_pp1_r [LANES];
  logic [W+C2:0]           s8_pp2_r [LANES];
  logic                    s8_neg_r [LANES];
  logic signed [W-1:0]     s8_v_r [LANES];
  logic [W:0]              lane_n [LANES];
  logic [KW-1:0]           lane_k [LANES];
  logic                    lane_neg [LANES];

  always_comb begin
    lane_n[LANE_FIRST_VX]   = s7_nxm_r;
    lane_n[LANE_FIRST_VY]   = s7_nym_r;
    lane_n[LANE_SECOND_VX]  = s7_nxm_r;
    lane_n[LANE_SECOND_VY]  = s7_nym_r;
    lane_k[LANE_FIRST_VX]   = s7_ka_r;
    lane_k[LANE_FIRST_VY]   = s7_ka_r;
    lane_k[LANE_SECOND_VX]  = s7_kb_r;
    lane_k[LANE_SECOND_VY]  = s7_kb_r;
    lane_neg[LANE_FIRST_VX]  = s7_nxneg_r ^ s7_dneg_r;
    lane_neg[LANE_FIRST_VY]  = s7_nyneg_r ^ s7_dneg_r;
    lane_neg[LANE_SECOND_VX] = s7_nxneg_r ^ !s7_dneg_r;
    lane_neg[LANE_SECOND_VY] = s7_nyneg_r ^ !s7_dneg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= s7_vld_r;
    end
    s8_hit_r <= s7_hit_r;
    s8_den_r <= s7_den_r;
    s8_v_r   <= s7_v_r;
    for (int l = 0; l < LANES; l++) begin
      s8_pp0_r[l] <= lane_n[l] * lane_k[l][C-1:0];
      s8_pp1_r[l] <= lane_n[l] * lane_k[l][2*C-1:C];
      s8_pp2_r[l] <= lane_n[l] * lane_k[l][KW-1:2*C];
      s8_neg_r[l] <= lane_neg[l];
    end
  end

  // Stage 9: dividends.
  logic                    s9_vld_r, s9_hit_r;
  logic [DENW-1:0]         s9_den_r;
  logic [PW-1:0]           s9_p_r [LANES];
  logic                    s9_neg_r [LANES];
  logic signed [W-1:0]     s9_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else begin
      s9_vld_r <= s8_vld_r;
    end
    s9_hit_r <= s8_hit_r;
    s9_den_r <= s8_den_r;
    s9_v_r   <= s8_v_r;
    s9_neg_r <= s8_neg_r;
    for (int l = 0; l < LANES; l++) begin
      s9_p_r[l] <= PW'(s8_pp0_r[l]) + (PW'(s8_pp1_r[l]) << C) +
                   (PW'(s8_pp2_r[l]) << (2 * C));
    end
  end

  // One pipelined divider per lane, all sharing the divisor.
  edc_ctl_t                dv_ctl [LANES];
  logic [QB-1:0]           dv_q   [LANES];
  logic                    dv_rnd [LANES];
  logic [W-1:0]            dv_val [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_div
    edc_ctl_t ctl_in;

    assign ctl_in = '{vld: s9_vld_r, hit: s9_hit_r, neg: s9_neg_r[l]};

    edc_div #(
      .PW   (PW),
      .DENW (DENW),
      .QB   (QB),
      .VW   (W)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (ctl_in),
      .in_num  (s9_p_r[l]),
      .in_den  (s9_den_r),
      .in_val  (s9_v_r[l]),
      .out_ctl (dv_ctl[l]),
      .out_q   (dv_q[l]),
      .out_rnd (dv_rnd[l]),
      .out_val (dv_val[l])
    );
  end

  // Stage A: rounded correction magnitude.
  logic                    a_vld_r, a_hit_r;
  logic [QB:0]             a_mag_r [LANES];
  logic                    a_neg_r [LANES];
  logic signed [W-1:0]     a_v_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= dv_ctl[LANE_FIRST_VX].vld;
    end
    a_hit_r <= dv_ctl[LANE_FIRST_VX].hit;
    for (int l = 0; l < LANES; l++) begin
      a_mag_r[l] <= (QB+1)'(dv_q[l]) + (QB+1)'(dv_rnd[l]);
      a_neg_r[l] <= dv_ctl[l].neg;
      a_v_r[l]   <= dv_val[l];
    end
  end

  // Stage B: add the signed correction to the incoming component.
  logic                    b_vld_r, b_hit_r;
  logic signed [SW-1:0]    b_sum_r [LANES];
  logic signed [W-1:0]     b_v_r [LANES];
  logic signed [SW-1:0]    sum_v [LANES];
  logic signed [SW-1:0]    sum_m [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum_v[l] = SW'(a_v_r[l]);
      sum_m[l] = signed'({2'b00, a_mag_r[l]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_hit_r <= a_hit_r;
    b_v_r   <= a_v_r;
    for (int l = 0; l < LANES; l++) begin
      b_sum_r[l] <= a_neg_r[l] ? (sum_v[l] - sum_m[l]) : (sum_v[l] + sum_m[l]);
    end
  end

  // Stage C: saturate, or pass the velocities through when there is no collision.
  logic                    out_valid_r, out_collided_r;
  logic signed [W-1:0]     out_v_r [LANES];
  logic signed [W-1:0]     sat_v [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if ((&b_sum_r[l][SW-1:W-1]) || !(|b_sum_r[l][SW-1:W-1])) begin
        sat_v[l] = b_sum_r[l][W-1:0];
      end else if (b_sum_r[l][SW-1]) begin
        sat_v[l] = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat_v[l] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      out_collided_r <= 1'b0;
    end else begin
      out_valid_r    <= b_vld_r;
      out_collided_r <= b_vld_r && b_hit_r;
    end
    for (int l = 0; l < LANES; l++) begin
      out_v_r[l] <= b_hit_r ? sat_v[l] : b_v_r[l];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_collided      = out_collided_r;
  assign out_new_first_vx  = out_v_r[LANE_FIRST_VX];
  assign out_new_first_vy  = out_v_r[LANE_FIRST_VY];
  assign out_new_second_vx = out_v_r[LANE_SECOND_VX];
  assign out_new_second_vy = out_v_r[LANE_SECOND_VY];

`ifndef SYNTHESIS
  // A collision is only flagged on a result strobe.
  a_collided_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_collided |-> out_valid)
    else $error("collided set without a result strobe");

  // A colliding pair never reaches the divider with a zero divisor.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (s7_vld_r && s7_hit_r) |-> (s7_den_r != '0))
    else $error("zero divisor on a colliding pair");

  // The four divider lanes stay in lockstep.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_ctl[LANE_FIRST_VX].vld == dv_ctl[LANE_SECOND_VY].vld) &&
    (dv_ctl[LANE_FIRST_VY].vld == dv_ctl[LANE_SECOND_VX].vld) &&
    (!dv_ctl[LANE_FIRST_VX].vld ||
     (dv_ctl[LANE_FIRST_VX].hit == dv_ctl[LANE_SECOND_VY].hit)))
    else $error("divider lanes out of step");

  // A valid divider output is followed by a result strobe after stages A, B and C.
  a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
    dv_ctl[LANE_FIRST_VX].vld |=> ##2 out_valid)
    else $error("result strobe lost after the divider");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int VW = 32;
  localparam int WIDE = 192;
  localparam int LATENCY = VW + 18;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic signed [VW-1:0] x1, y1, vx1, vy1;
    logic [15:0]          m1;
    logic [VW-2:0]        r1;
    logic signed [VW-1:0] x2, y2, vx2, vy2;
    logic [15:0]          m2;
    logic [VW-2:0]        r2;
  } disk_pair_t;

  typedef struct {
    logic signed [VW-1:0] vx1, vy1, vx2, vy2;
    logic                 hit;
  } bounce_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [VW-1:0] in_first_x, in_first_y, in_first_vx, in_first_vy;
  logic [15:0] in_first_mass;
  logic [VW-2:0] in_first_radius;
  logic signed [VW-1:0] in_second_x, in_second_y, in_second_vx, in_second_vy;
  logic [15:0] in_second_mass;
  logic [VW-2:0] in_second_radius;
  logic out_valid;
  logic signed [VW-1:0] out_new_first_vx, out_new_first_vy;
  logic signed [VW-1:0] out_new_second_vx, out_new_second_vy;
  logic out_collided;

  bounce_t pending_bounces[$];
  int mismatches = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  elastic_disk_collision_top #(.VALUE_WIDTH(VW)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_first_vx(in_first_vx), .in_first_vy(in_first_vy),
    .in_first_mass(in_first_mass), .in_first_radius(in_first_radius),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_second_vx(in_second_vx), .in_second_vy(in_second_vy),
    .in_second_mass(in_second_mass), .in_second_radius(in_second_radius),
    .out_valid(out_valid),
    .out_new_first_vx(out_new_first_vx), .out_new_first_vy(out_new_first_vy),
    .out_new_second_vx(out_new_second_vx), .out_new_second_vy(out_new_second_vy),
    .out_collided(out_collided)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Rounds nc * k / den to the nearest integer, halves away from zero, and keeps the low 62 bits of the magnitude.
  function automatic logic signed [WIDE-1:0] scaled_share(
    input logic signed [WIDE-1:0] nc,
    input logic signed [WIDE-1:0] k,
    input logic signed [WIDE-1:0] den
  );
    logic signed [WIDE-1:0] prod, mag, quo, rem;
    prod = nc * k;
    mag = (prod < 0) ? -prod : prod;
    quo = mag / den;
    rem = mag % den;
    if (2 * rem >= den) begin
      quo = quo + 1;
    end
    quo = quo & ((WIDE'(1) <<< 62) - 1);
    return (prod < 0) ? -quo : quo;
  endfunction

  // Adds a correction to a velocity and clamps to the signed range.
  function automatic logic signed [VW-1:0] clamp_sum(
    input logic signed [VW-1:0] v,
    input logic signed [WIDE-1:0] corr
  );
    logic signed [WIDE-1:0] sum, vw, hi, lo;
    vw = v;
    hi = (WIDE'(1) <<< (VW - 1)) - 1;
    lo = -hi - 1;
    sum = vw + corr;
    if (sum > hi) return hi[VW-1:0];
    if (sum < lo) return lo[VW-1:0];
    return sum[VW-1:0];
  endfunction

  // Works out the velocities after an elastic collision of the two disks.
  function automatic bounce_t predict_bounce(input disk_pair_t p);
    bounce_t res;
    logic signed [WIDE-1:0] ax, ay, bx, by, av, aw, bv, bw;
    logic signed [WIDE-1:0] m1, m2, mt, r1, r2, nx, ny, dist2, rsum, diff, k1, k2, den;
    ax = p.x1; ay = p.y1; bx = p.x2; by = p.y2;
    av = p.vx1; aw = p.vy1; bv = p.vx2; bw = p.vy2;
    m1 = p.m1; m2 = p.m2; r1 = p.r1; r2 = p.r2;
    nx = bx - ax;
    ny = by - ay;
    mt = m1 + m2;
    dist2 = nx * nx + ny * ny;
    rsum = r1 + r2;
    res.vx1 = p.vx1; res.vy1 = p.vy1; res.vx2 = p.vx2; res.vy2 = p.vy2;
    res.hit = (dist2 != 0) && (dist2 <= rsum * rsum) && (mt != 0);
    if (res.hit) begin
      diff = (nx * bv + ny * bw) - (nx * av + ny * aw);
      k1 = 2 * m2 * diff;
      k2 = -(2 * m1 * diff);
      den = mt * dist2;
      res.vx1 = clamp_sum(p.vx1, scaled_share(nx, k1, den));
      res.vy1 = clamp_sum(p.vy1, scaled_share(ny, k1, den));
      res.vx2 = clamp_sum(p.vx2, scaled_share(nx, k2, den));
      res.vy2 = clamp_sum(p.vy2, scaled_share(ny, k2, den));
    end
    return res;
  endfunction

  // Offers one pair, waits for the transaction, and records its expected bounce.
  task automatic send_pair(input disk_pair_t p);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_first_x <= p.x1; in_first_y <= p.y1;
    in_first_vx <= p.vx1; in_first_vy <= p.vy1;
    in_first_mass <= p.m1; in_first_radius <= p.r1;
    in_second_x <= p.x2; in_second_y <= p.y2;
    in_second_vx <= p.vx2; in_second_vy <= p.vy2;
    in_second_mass <= p.m2; in_second_radius <= p.r2;
    do @(posedge clk); while (busy);
    pending_bounces = {pending_bounces, predict_bounce(p)};
  endtask

  function automatic disk_pair_t make_pair(
    input logic signed [VW-1:0] x1, y1, vx1, vy1,
    input int m1, input int r1,
    input logic signed [VW-1:0] x2, y2, vx2, vy2,
    input int m2, input int r2
  );
    disk_pair_t p;
    p.x1 = x1; p.y1 = y1; p.vx1 = vx1; p.vy1 = vy1;
    p.m1 = 16'(m1); p.r1 = (VW-1)'(r1);
    p.x2 = x2; p.y2 = y2; p.vx2 = vx2; p.vy2 = vy2;
    p.m2 = 16'(m2); p.r2 = (VW-1)'(r2);
    return p;
  endfunction

  function automatic logic [VW-2:0] rand_radius_below(input longint span);
    if (span > 32'h7fff_ffff) span = 32'h7fff_ffff;
    return (VW-1)'($urandom_range(0, 32'(span)));
  endfunction

  // Random pair: mostly close neighbors that may overlap, some fully random.
  function automatic disk_pair_t random_pair();
    disk_pair_t p;
    int sh;
    logic signed [VW-1:0] dx, dy;
    longint span;
    p.vx1 = $urandom; p.vy1 = $urandom; p.vx2 = $urandom; p.vy2 = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      sh = $urandom_range(0, 20);
      p.vx1 = p.vx1 >>> sh; p.vy1 = p.vy1 >>> sh;
      p.vx2 = p.vx2 >>> sh; p.vy2 = p.vy2 >>> sh;
    end
    p.m1 = 16'($urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 16));
    p.m2 = 16'($urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 16));
    p.x1 = $urandom; p.y1 = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      p.x2 = $urandom; p.y2 = $urandom;
      p.r1 = (VW-1)'($urandom); p.r2 = (VW-1)'($urandom);
    end else begin
      sh = $urandom_range(2, 31);
      dx = $signed($urandom) >>> sh;
      dy = $signed($urandom) >>> sh;
      p.x2 = p.x1 + dx;
      p.y2 = p.y1 + dy;
      span = (dx < 0 ? -longint'(dx) : longint'(dx)) + (dy < 0 ? -longint'(dy) : longint'(dy));
      p.r1 = rand_radius_below(span);
      p.r2 = rand_radius_below(span);
    end
    return p;
  endfunction

  // Corner cases: head-on hits, touching, coincident centers, extremes.
  task automatic test_directed();
    logic signed [VW-1:0] one, vmax, vmin;
    one = 32'sh0001_0000;
    vmax = 32'sh7fff_ffff;
    vmin = 32'sh8000_0000;
    // Equal masses head on along x: velocities swap.
    send_pair(make_pair(0, 0, one, 0, 1, one, one, 0, -one, 0, 1, one));
    // Exactly touching, then just apart.
    send_pair(make_pair(0, 0, one, one, 3, one, 2 * one, 0, 0, 0, 5, one));
    send_pair(make_pair(0, 0, one, one, 3, one, 2 * one + 1, 0, 0, 0, 5, one));
    // Coincident centers never collide.
    send_pair(make_pair(one, -one, one, 7, 9, one, one, -one, -one, 3, 9, one));
    // Zero radii, even adjacent centers are apart.
    send_pair(make_pair(0, 0, one, 0, 1, 0, 1, 0, 0, 0, 1, 0));
    // Diagonal hit with unequal masses at the mass extremes.
    send_pair(make_pair(0, 0, one, -one, 1, one, one, one, -one, one, 65535, one));
    send_pair(make_pair(0, 0, one, -one, 65535, one, one, one, -one, one, 1, one));
    // Saturation of the result velocities.
    send_pair(make_pair(0, 0, vmax, vmax, 65535, one, 1, 1, vmin, vmin, 1, one));
    send_pair(make_pair(0, 0, vmin, vmax, 1, one, 1, 0, vmax, vmin, 65535, one));
    // Extreme positions with the largest radii.
    send_pair(make_pair(vmin, vmin, one, one, 2, 31'h7fff_ffff,
                        vmax, vmax, -one, 0, 7, 31'h7fff_ffff));
    send_pair(make_pair(vmax, vmin, vmax, vmin, 65535, 31'h7fff_ffff,
                        vmin, vmax, vmin, vmax, 65535, 31'h7fff_ffff));
    send_pair(make_pair(vmin, 0, 0, 0, 1, 31'h7fff_ffff, vmax, 0, 0, 0, 1, 0));
    // Far apart, velocities pass through.
    send_pair(make_pair(vmin, vmin, 123, -456, 10, one, vmax, vmax, -789, 1011, 20, one));
    // Halfway rounding around odd fractions.
    send_pair(make_pair(0, 0, 1, 0, 3, 3, 3, 4, 0, 0, 1, 3));
    send_pair(make_pair(0, 0, -1, 1, 2, 5, 1, 2, 1, -1, 1, 5));
  endtask

  task automatic test_random(input int pct, input int count);
    idle_pct = pct;
    repeat (count) send_pair(random_pair());
  endtask

  // Compares every result with the oldest expectation.
  always @(posedge clk) begin
    bounce_t want;
    if (rst_n && out_valid) begin
      if (pending_bounces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $time);
      end else begin
        want = pending_bounces.pop_front();
        if (out_new_first_vx !== want.vx1 || out_new_first_vy !== want.vy1 ||
            out_new_second_vx !== want.vx2 || out_new_second_vy !== want.vy2 ||
            out_collided !== want.hit) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected %0d %0d %0d %0d hit %0b", $time,
                     want.vx1, want.vy1, want.vx2, want.vy2, want.hit);
            $display("  got %0d %0d %0d %0d hit %0b", out_new_first_vx,
                     out_new_first_vy, out_new_second_vx, out_new_second_vy, out_collided);
          end
        end
      end
    end
  end

  // Ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_first_x <= '0; in_first_y <= '0; in_first_vx <= '0; in_first_vy <= '0;
    in_first_mass <= 16'd1; in_first_radius <= '0;
    in_second_x <= '0; in_second_y <= '0; in_second_vx <= '0; in_second_vy <= '0;
    in_second_mass <= 16'd1; in_second_radius <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(33, 630);
    test_random(63, 630);
    test_random(0, 630);
    start <= 1'b0;
    while (pending_bounces.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
design/edc_pkg.sv
design/edc_div.sv
design/elastic_disk_collision_top.sv
tb/testbench.sv
